>>> design/first_fit_block_allocator_macros.svh
// Assertion helpers shared by the allocator RTL.
// Each macro expands to a labeled concurrent assertion on clk, gated by rst_n, unless ASSERT_OFF is defined.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication
`define FFBA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FFBA_ASSERT_IMPL(lbl, ante, cons, msg)
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> design/ffba_pkg.sv
package ffba_pkg;

    // Table geometry
    localparam int NUM_BLOCKS = 64;
    localparam int IDX_W      = $clog2(NUM_BLOCKS);
    localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

    // Field widths
    localparam int SIZE_W   = 27;
    localparam int ADDR_W   = 32;
    localparam int HDR_W    = 8;
    localparam int META_W   = 14;
    localparam int STATUS_W = 3;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W   = $clog2(SIZE_W);

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_CALLOC  = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE    = 2'd2;
    localparam logic [OP_W-1:0] OP_REALLOC = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_SIZE   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_HEAP_FULL  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_TABLE_FULL = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOOP       = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_CAP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LIMIT = 2'd2;

    // Configuration reset values
    localparam logic [ADDR_W-1:0] HEAP_CAP_RST   = 32'hFFFF_FFFF;
    localparam logic [HDR_W-1:0]  HEADER_RST     = 8'd32;
    localparam logic [SIZE_W-1:0] SIZE_LIMIT_RST = 27'd100_000_000;

    // One block table entry
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] size;
        logic              free;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Sequencer states
    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_MUL      = 7'b0000010,
        S_CHECK    = 7'b0000100,
        S_SCAN     = 7'b0001000,
        S_HCHK     = 7'b0010000,
        S_FREE_OLD = 7'b0100000,
        S_FINISH   = 7'b1000000
    } state_t;

endpackage

>>> design/ffba_ram.sv
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/first_fit_block_allocator.sv
// Every operation ends in the finish state, which registers done; calloc first runs a
// shift-add multiply of request size by element count.
// Throughput: one transaction at a time, set by the one-entry-per-cycle table walk
// through a single read port of the block table RAM.
// Reset clears counters and heap top and loads register defaults; table stays undefined.
// done pulses for one cycle and the receiver cannot stall it.
`include "first_fit_block_allocator_macros.svh"

module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [OP_W-1:0]      operation,
    input  logic [SIZE_W-1:0]    request_size,
    input  logic [SIZE_W-1:0]    element_count,
    input  logic                 handle_valid,
    input  logic [IDX_W-1:0]     block_handle,
    output logic                 done,
    output logic [STATUS_W-1:0]  status,
    output logic [IDX_W-1:0]     result_handle,
    output logic [ADDR_W-1:0]    data_address,
    output logic [CNT_W-1:0]     free_block_count,
    output logic [ADDR_W-1:0]    free_byte_count,
    output logic [CNT_W-1:0]     allocated_block_count,
    output logic [ADDR_W-1:0]    allocated_byte_count,
    output logic [META_W-1:0]    metadata_byte_count,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    // Control and counter state
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    entry_count_reg, entry_count_next;
    logic [ADDR_W-1:0]   heap_top_reg, heap_top_next;
    logic [CNT_W-1:0]    free_blocks_reg, free_blocks_next;
    logic [ADDR_W-1:0]   free_bytes_reg, free_bytes_next;
    logic [ADDR_W-1:0]   used_bytes_reg, used_bytes_next;
    logic [ADDR_W-1:0]   heap_cap_reg, heap_cap_next;
    logic [HDR_W-1:0]    header_reg, header_next;
    logic [SIZE_W-1:0]   size_limit_reg, size_limit_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                chk_valid_reg, chk_valid_next;
    logic                realloc_reg, realloc_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    // Payload state
    logic [OP_W-1:0]     op_reg, op_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [SIZE_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]    h_reg, h_next;
    logic [SIZE_W-1:0]   req_reg, req_next;
    logic                ovf_reg, ovf_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    entry_t              old_entry_reg, old_entry_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                have_reg, have_next;
    logic [IDX_W-1:0]    grant_idx_reg, grant_idx_next;
    logic [ADDR_W-1:0]   grant_base_reg, grant_base_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [IDX_W-1:0]    out_handle_reg, out_handle_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;
    logic [META_W-1:0]   out_meta_reg, out_meta_next;

    // Table RAM port
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    entry_t              ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    entry_t              rd_entry;

    // Shared datapath terms
    logic [SIZE_W+1:0]   mul_sum;
    logic [ADDR_W+1:0]   need_end;
    logic                scan_hit;
    logic                bad_size;
    logic [14:0]         meta_prod;

    ffba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);

    // Shift-add step, heap bound, fit test, size check
    assign mul_sum   = {1'b0, req_reg, 1'b0}
                     + (cnt_reg[SIZE_W-1] ? {2'b00, size_reg} : '0);
    assign need_end  = {2'b00, heap_top_reg} + {7'd0, req_reg}
                     + {{(ADDR_W + 2 - HDR_W){1'b0}}, header_reg};
    assign scan_hit  = chk_valid_reg && rd_entry.free && (rd_entry.size >= req_reg);
    assign bad_size  = ovf_reg || (req_reg == '0) || (req_reg > size_limit_reg);
    assign meta_prod = {{(15 - CNT_W){1'b0}}, entry_count_reg}
                     * {{(15 - HDR_W){1'b0}}, header_reg};

    // Sequencer and datapath
    always_comb
    begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        heap_top_next    = heap_top_reg;
        free_blocks_next = free_blocks_reg;
        free_bytes_next  = free_bytes_reg;
        used_bytes_next  = used_bytes_reg;
        heap_cap_next    = heap_cap_reg;
        header_next      = header_reg;
        size_limit_next  = size_limit_reg;
        done_next        = 1'b0;
        scan_idx_next    = scan_idx_reg;
        chk_valid_next   = chk_valid_reg;
        realloc_next     = realloc_reg;
        step_next        = step_reg;
        op_next          = op_reg;
        size_next        = size_reg;
        cnt_next         = cnt_reg;
        h_next           = h_reg;
        req_next         = req_reg;
        ovf_next         = ovf_reg;
        chk_idx_next     = chk_idx_reg;
        old_entry_next   = old_entry_reg;
        status_next      = status_reg;
        have_next        = have_reg;
        grant_idx_next   = grant_idx_reg;
        grant_base_next  = grant_base_reg;
        out_status_next  = out_status_reg;
        out_handle_next  = out_handle_reg;
        out_addr_next    = out_addr_reg;
        out_meta_next    = out_meta_reg;
        ram_we           = 1'b0;
        ram_waddr        = h_reg;
        ram_wdata        = '0;
        ram_raddr        = scan_idx_reg[IDX_W-1:0];

        // Take configuration writes
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_HEAP_CAP:   heap_cap_next   = cfg_data;
                CFG_HEADER:     header_next     = cfg_data[HDR_W-1:0];
                CFG_SIZE_LIMIT: size_limit_next = cfg_data[SIZE_W-1:0];
                default:        ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                // Read the named block early for free and reallocate
                ram_raddr = block_handle;
                if (start)
                begin
                    op_next        = operation;
                    size_next      = request_size;
                    cnt_next       = element_count;
                    h_next         = block_handle;
                    req_next       = request_size;
                    ovf_next       = 1'b0;
                    realloc_next   = 1'b0;
                    have_next      = 1'b0;
                    status_next    = STAT_NOOP;
                    scan_idx_next  = '0;
                    chk_valid_next = 1'b0;
                    step_next      = STEP_W'(SIZE_W - 1);
                    case (operation)
                        OP_ALLOC:  state_next = S_CHECK;
                        OP_CALLOC:
                        begin
                            req_next   = '0;
                            state_next = S_MUL;
                        end
                        OP_FREE:
                        begin
                            if (handle_valid && ({1'b0, block_handle} < entry_count_reg))
                                state_next = S_HCHK;
                            else
                                state_next = S_FINISH;
                        end
                        OP_REALLOC:
                        begin
                            if (!handle_valid)
                                state_next = S_CHECK;
                            else if ({1'b0, block_handle} < entry_count_reg)
                                state_next = S_HCHK;
                            else
                                state_next = S_FINISH;
                        end
                        default:   state_next = S_FINISH;
                    endcase
                end
            end

            S_MUL:
            begin
                // One product bit per cycle, MSB first; stop and flag overflow past the limit
                if (!ovf_reg)
                begin
                    if (mul_sum > {2'b00, size_limit_reg})
                        ovf_next = 1'b1;
                    else
                        req_next = mul_sum[SIZE_W-1:0];
                end
                cnt_next  = {cnt_reg[SIZE_W-2:0], 1'b0};
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                    state_next = S_CHECK;
            end

            S_CHECK:
            begin
                if (bad_size)
                begin
                    status_next = STAT_BAD_SIZE;
                    state_next  = S_FINISH;
                end
                else
                begin
                    scan_idx_next  = '0;
                    chk_valid_next = 1'b0;
                    state_next     = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (scan_hit)
                begin
                    // Take the first free block that fits, whole
                    ram_we           = 1'b1;
                    ram_waddr        = chk_idx_reg;
                    ram_wdata.base   = rd_entry.base;
                    ram_wdata.size   = rd_entry.size;
                    ram_wdata.free   = 1'b0;
                    free_blocks_next = free_blocks_reg - 1'b1;
                    free_bytes_next  = free_bytes_reg - {5'd0, rd_entry.size};
                    grant_idx_next   = chk_idx_reg;
                    grant_base_next  = rd_entry.base;
                    have_next        = 1'b1;
                    status_next      = STAT_OK;
                    state_next       = realloc_reg ? S_FREE_OLD : S_FINISH;
                end
                else if (scan_idx_reg < entry_count_reg)
                begin
                    // Advance the walk by one entry
                    chk_idx_next   = scan_idx_reg[IDX_W-1:0];
                    chk_valid_next = 1'b1;
                    scan_idx_next  = scan_idx_reg + 1'b1;
                end
                else if (chk_valid_reg)
                begin
                    // Drain the last read
                    chk_valid_next = 1'b0;
                end
                else if (entry_count_reg >= CNT_W'(NUM_BLOCKS))
                begin
                    status_next = STAT_TABLE_FULL;
                    state_next  = S_FINISH;
                end
                else if (need_end > {2'b00, heap_cap_reg})
                begin
                    status_next = STAT_HEAP_FULL;
                    state_next  = S_FINISH;
                end
                else
                begin
                    // Append a new block at the heap top
                    ram_we           = 1'b1;
                    ram_waddr        = entry_count_reg[IDX_W-1:0];
                    ram_wdata.base   = heap_top_reg;
                    ram_wdata.size   = req_reg;
                    ram_wdata.free   = 1'b0;
                    heap_top_next    = need_end[ADDR_W-1:0];
                    used_bytes_next  = used_bytes_reg + {5'd0, req_reg};
                    entry_count_next = entry_count_reg + 1'b1;
                    grant_idx_next   = entry_count_reg[IDX_W-1:0];
                    grant_base_next  = heap_top_reg;
                    have_next        = 1'b1;
                    status_next      = STAT_OK;
                    state_next       = realloc_reg ? S_FREE_OLD : S_FINISH;
                end
            end

            S_HCHK:
            begin
                if (op_reg == OP_FREE)
                begin
                    // Mark the block free unless it already is
                    if (!rd_entry.free)
                    begin
                        ram_we           = 1'b1;
                        ram_waddr        = h_reg;
                        ram_wdata.base   = rd_entry.base;
                        ram_wdata.size   = rd_entry.size;
                        ram_wdata.free   = 1'b1;
                        free_blocks_next = free_blocks_reg + 1'b1;
                        free_bytes_next  = free_bytes_reg + {5'd0, rd_entry.size};
                        grant_idx_next   = h_reg;
                        grant_base_next  = rd_entry.base;
                        have_next        = 1'b1;
                        status_next      = STAT_OK;
                    end
                    state_next = S_FINISH;
                end
                else if (rd_entry.size >= size_reg)
                begin
                    // Keep a block that is already large enough
                    grant_idx_next  = h_reg;
                    grant_base_next = rd_entry.base;
                    have_next       = 1'b1;
                    status_next     = STAT_OK;
                    state_next      = S_FINISH;
                end
                else
                begin
                    // Hold the old entry and allocate anew
                    old_entry_next = rd_entry;
                    realloc_next   = 1'b1;
                    state_next     = S_CHECK;
                end
            end

            S_FREE_OLD:
            begin
                if (!old_entry_reg.free)
                begin
                    ram_we           = 1'b1;
                    ram_waddr        = h_reg;
                    ram_wdata.base   = old_entry_reg.base;
                    ram_wdata.size   = old_entry_reg.size;
                    ram_wdata.free   = 1'b1;
                    free_blocks_next = free_blocks_reg + 1'b1;
                    free_bytes_next  = free_bytes_reg + {5'd0, old_entry_reg.size};
                end
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                // Register the result transaction
                done_next       = 1'b1;
                out_status_next = status_reg;
                out_handle_next = have_reg ? grant_idx_reg : '0;
                out_addr_next   = have_reg ? (grant_base_reg + {24'd0, header_reg}) : '0;
                out_meta_next   = meta_prod[META_W-1:0];
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control, counters and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            entry_count_reg <= '0;
            heap_top_reg    <= '0;
            free_blocks_reg <= '0;
            free_bytes_reg  <= '0;
            used_bytes_reg  <= '0;
            heap_cap_reg    <= HEAP_CAP_RST;
            header_reg      <= HEADER_RST;
            size_limit_reg  <= SIZE_LIMIT_RST;
            done_reg        <= 1'b0;
            scan_idx_reg    <= '0;
            chk_valid_reg   <= 1'b0;
            realloc_reg     <= 1'b0;
            step_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            heap_top_reg    <= heap_top_next;
            free_blocks_reg <= free_blocks_next;
            free_bytes_reg  <= free_bytes_next;
            used_bytes_reg  <= used_bytes_next;
            heap_cap_reg    <= heap_cap_next;
            header_reg      <= header_next;
            size_limit_reg  <= size_limit_next;
            done_reg        <= done_next;
            scan_idx_reg    <= scan_idx_next;
            chk_valid_reg   <= chk_valid_next;
            realloc_reg     <= realloc_next;
            step_reg        <= step_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        size_reg       <= size_next;
        cnt_reg        <= cnt_next;
        h_reg          <= h_next;
        req_reg        <= req_next;
        ovf_reg        <= ovf_next;
        chk_idx_reg    <= chk_idx_next;
        old_entry_reg  <= old_entry_next;
        status_reg     <= status_next;
        have_reg       <= have_next;
        grant_idx_reg  <= grant_idx_next;
        grant_base_reg <= grant_base_next;
        out_status_reg <= out_status_next;
        out_handle_reg <= out_handle_next;
        out_addr_reg   <= out_addr_next;
        out_meta_reg   <= out_meta_next;
    end

    // Ports
    assign busy                  = (state_reg != S_IDLE);
    assign cfg_ready             = 1'b1;
    assign done                  = done_reg;
    assign status                = out_status_reg;
    assign result_handle         = out_handle_reg;
    assign data_address          = out_addr_reg;
    assign free_block_count      = free_blocks_reg;
    assign free_byte_count       = free_bytes_reg;
    assign allocated_block_count = entry_count_reg;
    assign allocated_byte_count  = used_bytes_reg;
    assign metadata_byte_count   = out_meta_reg;

    `FFBA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
    `FFBA_ASSERT_NEXT(a_finish_done, state_reg == S_FINISH, done, "finish did not strobe done")
    `FFBA_ASSERT_IMPL(a_free_le_count, 1'b1, free_blocks_reg <= entry_count_reg, "free blocks exceed table")
    `FFBA_ASSERT_IMPL(a_count_le_max, 1'b1, entry_count_reg <= CNT_W'(NUM_BLOCKS), "table count overflow")
    `FFBA_ASSERT_IMPL(a_fail_zero, done && (status != STAT_OK), (result_handle == '0) && (data_address == '0), "failed result carries handle")

endmodule

>>> tb/sv/tb_first_fit_block_allocator.sv
`timescale 1ns / 1ps

module tb_first_fit_block_allocator;
    import ffba_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 120;
    localparam int LIMIT_MAX      = 100_000_000;

    // One expected or observed transaction report
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    handle;
        logic [ADDR_W-1:0]   addr;
        logic [CNT_W-1:0]    free_blocks;
        logic [ADDR_W-1:0]   free_bytes;
        logic [CNT_W-1:0]    alloc_blocks;
        logic [ADDR_W-1:0]   alloc_bytes;
        logic [META_W-1:0]   meta_bytes;
    } heap_report_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [OP_W-1:0]      operation;
    logic [SIZE_W-1:0]    request_size;
    logic [SIZE_W-1:0]    element_count;
    logic                 handle_valid;
    logic [IDX_W-1:0]     block_handle;
    logic                 done;
    logic [STATUS_W-1:0]  status;
    logic [IDX_W-1:0]     result_handle;
    logic [ADDR_W-1:0]    data_address;
    logic [CNT_W-1:0]     free_block_count;
    logic [ADDR_W-1:0]    free_byte_count;
    logic [CNT_W-1:0]     allocated_block_count;
    logic [ADDR_W-1:0]    allocated_byte_count;
    logic [META_W-1:0]    metadata_byte_count;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;

    // Shadow copy of the allocator: registers, block table and tallies
    logic [ADDR_W-1:0] heap_cap_reg = HEAP_CAP_RST;
    logic [HDR_W-1:0]  header_reg   = HEADER_RST;
    logic [SIZE_W-1:0] limit_reg    = SIZE_LIMIT_RST;
    logic [SIZE_W-1:0] blk_size [NUM_BLOCKS];
    logic              blk_free [NUM_BLOCKS];
    logic [ADDR_W-1:0] blk_base [NUM_BLOCKS];
    int unsigned       n_entries        = 0;
    logic [ADDR_W-1:0] heap_top         = '0;
    logic [CNT_W-1:0]  free_block_tally = '0;
    logic [ADDR_W-1:0] free_byte_tally  = '0;
    logic [ADDR_W-1:0] used_byte_tally  = '0;

    heap_report_t pending_reports[$];
    int           mismatch_count = 0;
    int           idle_cycles    = 0;
    int unsigned  burst_left     = 0;

    first_fit_block_allocator dut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .start                 (start),
        .busy                  (busy),
        .operation             (operation),
        .request_size          (request_size),
        .element_count         (element_count),
        .handle_valid          (handle_valid),
        .block_handle          (block_handle),
        .done                  (done),
        .status                (status),
        .result_handle         (result_handle),
        .data_address          (data_address),
        .free_block_count      (free_block_count),
        .free_byte_count       (free_byte_count),
        .allocated_block_count (allocated_block_count),
        .allocated_byte_count  (allocated_byte_count),
        .metadata_byte_count   (metadata_byte_count),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // First fit over existing blocks, else append at the heap top
    function automatic logic [STATUS_W-1:0] grant_block(input longint unsigned need,
                                                        output int unsigned slot);
        longint unsigned span;
        longint unsigned top64;
        int unsigned     i;
        slot = 0;
        if (need == 0 || need > limit_reg)
            return STAT_BAD_SIZE;
        for (i = 0; i < n_entries; i++)
        begin
            if (blk_free[i] && blk_size[i] >= need)
            begin
                blk_free[i] = 1'b0;
                free_block_tally = free_block_tally - 1'b1;
                free_byte_tally  = free_byte_tally - blk_size[i];
                slot = i;
                return STAT_OK;
            end
        end
        if (n_entries >= NUM_BLOCKS)
            return STAT_TABLE_FULL;
        span  = need + header_reg;
        top64 = heap_top;
        if (top64 + span > heap_cap_reg)
            return STAT_HEAP_FULL;
        slot = n_entries;
        blk_base[slot] = heap_top;
        blk_size[slot] = need[SIZE_W-1:0];
        blk_free[slot] = 1'b0;
        heap_top = heap_top + span[ADDR_W-1:0];
        used_byte_tally = used_byte_tally + need[ADDR_W-1:0];
        n_entries++;
        return STAT_OK;
    endfunction

    // Mark a block free; report whether anything changed
    function automatic logic release_block(input int unsigned slot);
        if (blk_free[slot])
            return 1'b0;
        blk_free[slot] = 1'b1;
        free_block_tally = free_block_tally + 1'b1;
        free_byte_tally  = free_byte_tally + blk_size[slot];
        return 1'b1;
    endfunction

    // Advance the shadow allocator by one transaction and form its report
    function automatic heap_report_t model_request(input logic [OP_W-1:0] op,
                                                   input logic [SIZE_W-1:0] size,
                                                   input logic [SIZE_W-1:0] count,
                                                   input logic hv,
                                                   input logic [IDX_W-1:0] handle);
        heap_report_t        rpt;
        logic [STATUS_W-1:0] st;
        int unsigned         slot;
        logic                granted;
        longint unsigned     product;
        st      = STAT_NOOP;
        slot    = 0;
        granted = 1'b0;
        case (op)
            OP_ALLOC:
            begin
                st = grant_block(size, slot);
                granted = (st == STAT_OK);
            end
            OP_CALLOC:
            begin
                product = size;
                product = product * count;
                st = grant_block(product, slot);
                granted = (st == STAT_OK);
            end
            OP_FREE:
            begin
                if (hv && handle < n_entries)
                begin
                    if (release_block(handle))
                    begin
                        st = STAT_OK;
                        slot = handle;
                        granted = 1'b1;
                    end
                end
            end
            OP_REALLOC:
            begin
                if (!hv)
                begin
                    st = grant_block(size, slot);
                    granted = (st == STAT_OK);
                end
                else if (handle < n_entries)
                begin
                    if (blk_size[handle] >= size)
                    begin
                        st = STAT_OK;
                        slot = handle;
                        granted = 1'b1;
                    end
                    else
                    begin
                        st = grant_block(size, slot);
                        if (st == STAT_OK)
                        begin
                            granted = 1'b1;
                            void'(release_block(handle));
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        rpt.status       = st;
        rpt.handle       = granted ? slot[IDX_W-1:0] : '0;
        rpt.addr         = granted ? blk_base[slot] + header_reg : '0;
        rpt.free_blocks  = free_block_tally;
        rpt.free_bytes   = free_byte_tally;
        rpt.alloc_blocks = n_entries[CNT_W-1:0];
        rpt.alloc_bytes  = used_byte_tally;
        rpt.meta_bytes   = n_entries * header_reg;
        return rpt;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [ADDR_W-1:0] value);
        case (idx)
            CFG_HEAP_CAP:   heap_cap_reg = value;
            CFG_HEADER:     header_reg   = value[HDR_W-1:0];
            CFG_SIZE_LIMIT: limit_reg    = value[SIZE_W-1:0];
            default:
            begin
            end
        endcase
    endfunction

    task automatic compare_report(input heap_report_t want, input heap_report_t got);
        if (got.status !== want.status)
            $error("status: expected %0d, got %0d", want.status, got.status);
        if (got.handle !== want.handle)
            $error("result_handle: expected %0d, got %0d", want.handle, got.handle);
        if (got.addr !== want.addr)
            $error("data_address: expected %0h, got %0h", want.addr, got.addr);
        if (got.free_blocks !== want.free_blocks)
            $error("free_block_count: expected %0d, got %0d",
                   want.free_blocks, got.free_blocks);
        if (got.free_bytes !== want.free_bytes)
            $error("free_byte_count: expected %0d, got %0d",
                   want.free_bytes, got.free_bytes);
        if (got.alloc_blocks !== want.alloc_blocks)
            $error("allocated_block_count: expected %0d, got %0d",
                   want.alloc_blocks, got.alloc_blocks);
        if (got.alloc_bytes !== want.alloc_bytes)
            $error("allocated_byte_count: expected %0d, got %0d",
                   want.alloc_bytes, got.alloc_bytes);
        if (got.meta_bytes !== want.meta_bytes)
            $error("metadata_byte_count: expected %0d, got %0d",
                   want.meta_bytes, got.meta_bytes);
        if (got !== want)
            mismatch_count++;
    endtask

    // Check each result, predict each accepted transaction, track register writes
    always @(posedge clk)
    begin
        heap_report_t got;
        if (rst_n)
        begin
            if (done)
            begin
                got = {status, result_handle, data_address, free_block_count,
                       free_byte_count, allocated_block_count, allocated_byte_count,
                       metadata_byte_count};
                if (pending_reports.size() == 0)
                begin
                    $error("result with no transaction outstanding");
                    mismatch_count++;
                end
                else
                    compare_report(pending_reports.pop_front(), got);
            end
            if (start && !busy)
                pending_reports.push_back(model_request(operation, request_size,
                                                        element_count, handle_valid,
                                                        block_handle));
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Send one transaction; bursts of random length with random gaps between them
    task automatic issue_request(input logic [OP_W-1:0] op, input logic [SIZE_W-1:0] size,
                                 input logic [SIZE_W-1:0] count, input logic hv,
                                 input logic [IDX_W-1:0] handle);
        int unsigned gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                gap = $urandom_range(1, 12);
                @(negedge clk);
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        start         <= 1'b1;
        operation     <= op;
        request_size  <= size;
        element_count <= count;
        handle_valid  <= hv;
        block_handle  <= handle;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Hold off new transactions until every expected result is back
    task automatic drain_pending();
        @(negedge clk);
        start <= 1'b0;
        while (pending_reports.size() != 0 || busy)
            @(negedge clk);
        burst_left = 0;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [ADDR_W-1:0] value);
        drain_pending();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return '0;
        else if (roll < 70)
            return $urandom_range(1, 256);
        else if (roll < 85)
            return $urandom_range(257, 65536);
        else if (roll < 95)
            return $urandom_range(1, limit_reg);
        return $urandom;
    endfunction

    function automatic logic [SIZE_W-1:0] pick_count();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return '0;
        else if (roll < 85)
            return $urandom_range(1, 16);
        else if (roll < 95)
            return $urandom_range(1, 4096);
        return $urandom;
    endfunction

    // Mostly handles of live blocks, some null and some arbitrary
    function automatic void pick_handle(output logic hv, output logic [IDX_W-1:0] handle);
        int unsigned roll;
        roll   = $urandom_range(0, 99);
        hv     = (roll >= 10);
        handle = $urandom;
        if (roll >= 20 && n_entries > 0)
            handle = $urandom_range(0, n_entries - 1);
    endfunction

    task automatic run_random_traffic(input int unsigned n_items);
        int unsigned         roll;
        logic [OP_W-1:0]     op;
        logic                hv;
        logic [IDX_W-1:0]    handle;
        repeat (n_items)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 35)
                op = OP_ALLOC;
            else if (roll < 50)
                op = OP_CALLOC;
            else if (roll < 78)
                op = OP_FREE;
            else
                op = OP_REALLOC;
            pick_handle(hv, handle);
            issue_request(op, pick_size(), pick_count(), hv, handle);
        end
    endtask

    // Rejected sizes and no-op handles on an empty table
    task automatic test_bad_sizes();
        issue_request(OP_ALLOC, 0, 0, 1'b0, 0);
        issue_request(OP_ALLOC, LIMIT_MAX + 1, 0, 1'b0, 0);
        issue_request(OP_ALLOC, '1, '1, 1'b1, '1);
        issue_request(OP_CALLOC, 7, 0, 1'b0, 0);
        issue_request(OP_CALLOC, 0, 7, 1'b0, 0);
        issue_request(OP_CALLOC, '1, '1, 1'b0, 0);
        issue_request(OP_CALLOC, 10000, 10001, 1'b0, 0);
        issue_request(OP_FREE, 16, 0, 1'b0, 0);
        issue_request(OP_FREE, 16, 0, 1'b1, 5);
        issue_request(OP_REALLOC, 16, 0, 1'b1, 63);
    endtask

    // Allocation, reuse, double free and the reallocate paths
    task automatic test_alloc_free();
        issue_request(OP_ALLOC, 100, 0, 1'b0, 0);
        issue_request(OP_CALLOC, 10, 20, 1'b0, 0);
        issue_request(OP_CALLOC, 10000, 10000, 1'b0, 0);
        issue_request(OP_REALLOC, 50, 0, 1'b0, 0);
        issue_request(OP_FREE, 0, 0, 1'b1, 1);
        issue_request(OP_FREE, 0, 0, 1'b1, 1);
        issue_request(OP_ALLOC, 150, 0, 1'b0, 0);
        issue_request(OP_REALLOC, 100, 0, 1'b1, 0);
        issue_request(OP_REALLOC, 0, 0, 1'b1, 0);
        issue_request(OP_REALLOC, 300, 0, 1'b1, 0);
        issue_request(OP_REALLOC, 80, 0, 1'b1, 0);
        issue_request(OP_REALLOC, LIMIT_MAX + 1, 0, 1'b1, 3);
        issue_request(OP_FREE, 0, 0, 1'b1, 3);
        issue_request(OP_ALLOC, 1, 0, 1'b0, 0);
    endtask

    // Heap capacity at zero and at the exact boundary of one new block
    task automatic test_heap_limit();
        write_register(CFG_HEAP_CAP, '0);
        issue_request(OP_ALLOC, 5000, 0, 1'b0, 0);
        drain_pending();
        write_register(CFG_HEAP_CAP, heap_top + header_reg + 5000);
        issue_request(OP_ALLOC, 5000, 0, 1'b0, 0);
        issue_request(OP_ALLOC, 5000, 0, 1'b0, 0);
        write_register(CFG_HEAP_CAP, '1);
    endtask

    // Header and size limit at both ends of their range
    task automatic test_register_extremes();
        write_register(CFG_HEADER, '0);
        issue_request(OP_ALLOC, 7, 0, 1'b0, 0);
        write_register(CFG_HEADER, 8'hFF);
        issue_request(OP_ALLOC, 7, 0, 1'b0, 0);
        write_register(CFG_SIZE_LIMIT, 1);
        issue_request(OP_ALLOC, 1, 0, 1'b0, 0);
        issue_request(OP_ALLOC, 2, 0, 1'b0, 0);
        issue_request(OP_CALLOC, 1, 1, 1'b0, 0);
        issue_request(OP_REALLOC, 2, 0, 1'b1, 1);
        write_register(CFG_SIZE_LIMIT, LIMIT_MAX);
    endtask

    task automatic test_random_heap_pressure();
        drain_pending();
        write_register(CFG_HEAP_CAP, heap_top + $urandom_range(0, 20000));
        write_register(CFG_HEADER, $urandom_range(0, 255));
        run_random_traffic(150);
    endtask

    task automatic test_random_small_limit();
        write_register(CFG_HEAP_CAP, '1);
        write_register(CFG_HEADER, '0);
        write_register(CFG_SIZE_LIMIT, $urandom_range(1, 4096));
        run_random_traffic(200);
    endtask

    task automatic test_random_default();
        write_register(CFG_SIZE_LIMIT, LIMIT_MAX);
        write_register(CFG_HEADER, $urandom_range(0, 255));
        run_random_traffic(300);
    endtask

    task automatic test_random_wide_headers();
        write_register(CFG_HEADER, 8'hFF);
        run_random_traffic(300);
    endtask

    // Fill the table with blocks no free block can serve, then ask once more
    task automatic test_table_exhausted();
        int unsigned       tries;
        int unsigned       i;
        logic [SIZE_W-1:0] need;
        for (tries = 0; tries < 70; tries++)
        begin
            drain_pending();
            need = 1;
            for (i = 0; i < n_entries; i++)
                if (blk_free[i] && blk_size[i] >= need)
                    need = blk_size[i] + 1;
            if (need > limit_reg)
                need = limit_reg;
            issue_request(OP_ALLOC, need, 0, 1'b0, 0);
            if (n_entries >= NUM_BLOCKS)
                break;
        end
        drain_pending();
        issue_request(OP_ALLOC, limit_reg, 0, 1'b0, 0);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        operation     = OP_ALLOC;
        request_size  = '0;
        element_count = '0;
        handle_valid  = 1'b0;
        block_handle  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_HEAP_CAP;
        cfg_data      = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_bad_sizes();
        test_alloc_free();
        test_heap_limit();
        test_register_extremes();
        test_random_heap_pressure();
        test_random_small_limit();
        test_random_default();
        test_random_wide_headers();
        test_table_exhausted();

        // Let the last results land, then allow for a late stray result
        drain_pending();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_reports.size() != 0)
        begin
            $error("%0d results never arrived", pending_reports.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/ffba_pkg.sv
design/ffba_ram.sv
design/first_fit_block_allocator.sv
tb/sv/tb_first_fit_block_allocator.sv
